FILE: design/sdm_pkg.sv
// Types, constants and fixed-point helpers for the surround-to-stereo downmix.
// Used by the channel interfaces, the datapath and the top level.
`default_nettype none

package sdm_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [29:0] sur_prod_t;
    typedef logic signed [17:0] sum_t;
    typedef logic signed [31:0] mix_prod_t;
    typedef logic        [3:0]  chan_count_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } pipe_ctrl_t;

    localparam sur_prod_t   SUR_NUM        = 30'sd5818;
    localparam int          SUR_SHIFT      = 13;
    localparam mix_prod_t   MIX_NUM        = 32'sd5248;
    localparam int          MIX_SHIFT      = 14;
    localparam sum_t        SAT_MAX        = 18'sd32767;
    localparam sum_t        SAT_MIN        = -18'sd32768;
    localparam chan_count_t MIX_COUNT      = 4'd6;
    localparam chan_count_t CH_COUNT_RESET = 4'd6;

    // Divide by 8192 with truncation toward zero.
    function automatic sample_t sur_scale(sur_prod_t p);
        sur_prod_t q;
        q = p >>> SUR_SHIFT;
        if (p[29] && (p[SUR_SHIFT-1:0] != '0))
        begin
            q = q + 30'sd1;
        end
        return q[15:0];
    endfunction

    // Divide by 16384 with truncation toward zero.
    function automatic sum_t mix_scale(mix_prod_t p);
        mix_prod_t q;
        q = p >>> MIX_SHIFT;
        if (p[31] && (p[MIX_SHIFT-1:0] != '0))
        begin
            q = q + 32'sd1;
        end
        return q[17:0];
    endfunction

    function automatic sample_t sat16(sum_t x);
        sample_t r;
        if (x > SAT_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (x < SAT_MIN)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/sdm_frame_if.sv
// Input channel: one six-channel PCM frame per word, valid/ready handshake.
// Depends on sdm_pkg for the sample type.
`default_nettype none

interface sdm_frame_if;
    import sdm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t front_left;
    sample_t front_right;
    sample_t centre;
    sample_t bass_channel;
    sample_t surround_left;
    sample_t surround_right;

    modport source (
        output valid, front_left, front_right, centre, bass_channel,
               surround_left, surround_right,
        input  ready
    );

    modport sink (
        input  valid, front_left, front_right, centre, bass_channel,
               surround_left, surround_right,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/sdm_stereo_if.sv
// Output channel: one stereo pair per word, valid/ready handshake.
// Depends on sdm_pkg for the sample type.
`default_nettype none

interface sdm_stereo_if;
    import sdm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (
        output valid, left_out, right_out,
        input  ready
    );

    modport sink (
        input  valid, left_out, right_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/sdm_datapath.sv
// Four-stage payload pipeline: surround scaling, side sums, mix scaling, saturation.
// Depends on sdm_pkg; stage loads come from the top level's handshake control.
`default_nettype none

module sdm_datapath (
    input  wire logic               clk,
    input  wire sdm_pkg::pipe_ctrl_t ctrl,
    input  wire logic               mix_mode,
    input  wire sdm_pkg::sample_t   front_left,
    input  wire sdm_pkg::sample_t   front_right,
    input  wire sdm_pkg::sample_t   centre,
    input  wire sdm_pkg::sample_t   surround_left,
    input  wire sdm_pkg::sample_t   surround_right,
    output sdm_pkg::sample_t        left_out,
    output sdm_pkg::sample_t        right_out
);
    import sdm_pkg::*;

    logic      mode1_reg, mode2_reg, mode3_reg;
    sample_t   fl1_reg, fr1_reg;
    sur_prod_t pc1_reg, psl1_reg, psr1_reg;
    sum_t      suml2_reg, sumr2_reg;
    mix_prod_t pl3_reg, pr3_reg;
    sample_t   passl3_reg, passr3_reg;
    sample_t   left4_reg, right4_reg;

    sum_t      suml_next, sumr_next;
    sample_t   c_scaled, sl_scaled, sr_scaled;

    always_comb
    begin
        c_scaled  = sur_scale(pc1_reg);
        sl_scaled = sur_scale(psl1_reg);
        sr_scaled = sur_scale(psr1_reg);
        if (mode1_reg)
        begin
            suml_next = sum_t'(fl1_reg) + sum_t'(c_scaled) + sum_t'(sl_scaled);
            sumr_next = sum_t'(fr1_reg) + sum_t'(c_scaled) + sum_t'(sr_scaled);
        end
        else
        begin
            suml_next = sum_t'(fl1_reg);
            sumr_next = sum_t'(fr1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            mode1_reg <= mix_mode;
            fl1_reg   <= front_left;
            fr1_reg   <= front_right;
            pc1_reg   <= sur_prod_t'(centre) * SUR_NUM;
            psl1_reg  <= sur_prod_t'(surround_left) * SUR_NUM;
            psr1_reg  <= sur_prod_t'(surround_right) * SUR_NUM;
        end
        if (ctrl.load2)
        begin
            mode2_reg <= mode1_reg;
            suml2_reg <= suml_next;
            sumr2_reg <= sumr_next;
        end
        if (ctrl.load3)
        begin
            mode3_reg  <= mode2_reg;
            pl3_reg    <= mix_prod_t'(suml2_reg) * MIX_NUM;
            pr3_reg    <= mix_prod_t'(sumr2_reg) * MIX_NUM;
            passl3_reg <= suml2_reg[15:0];
            passr3_reg <= sumr2_reg[15:0];
        end
        if (ctrl.load4)
        begin
            left4_reg  <= mode3_reg ? sat16(mix_scale(pl3_reg)) : passl3_reg;
            right4_reg <= mode3_reg ? sat16(mix_scale(pr3_reg)) : passr3_reg;
        end
    end

    assign left_out  = left4_reg;
    assign right_out = right4_reg;

endmodule

`default_nettype wire

FILE: design/surround_downmix_to_stereo_top.sv
// Top level of the surround-to-stereo downmix: configuration register,
// pipeline handshake control and assertions. Depends on sdm_pkg, the two
// channel interfaces and sdm_datapath.
//
// Usage: frame words enter on the frame channel and stereo words leave on
// the stereo channel, both with valid/ready handshakes. The user must write
// the channel count through wr_en/wr_data only while the block is idle; the
// block itself does not enforce this. A count of six gives the weighted
// downmix, any other count passes the front pair through. Throughput is one
// word per cycle while the receiver is ready, through four register stages
// (products, side sums, mix product, truncation and saturation), each of
// which takes a new word whenever it is empty or its successor advances.
// When the receiver stalls, the output word holds and the stages fill in
// turn; frame.ready falls only once all four stages are full, so no word is
// lost or repeated. Reset empties the pipeline and sets the count to six.
`default_nettype none

module surround_downmix_to_stereo_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire sdm_pkg::chan_count_t wr_data,
    sdm_frame_if.sink              frame,
    sdm_stereo_if.source           stereo
);
    import sdm_pkg::*;

    chan_count_t count_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    pipe_ctrl_t  ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CH_COUNT_RESET;
        end
        else if (wr_en)
        begin
            count_reg <= wr_data;
        end
    end

    assign rdy4 = !v4_reg || stereo.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctrl.load1 = rdy1 && frame.valid;
    assign ctrl.load2 = rdy2 && v1_reg;
    assign ctrl.load3 = rdy3 && v2_reg;
    assign ctrl.load4 = rdy4 && v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= frame.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    sdm_datapath u_datapath (
        .clk            (clk),
        .ctrl           (ctrl),
        .mix_mode       (count_reg == MIX_COUNT),
        .front_left     (frame.front_left),
        .front_right    (frame.front_right),
        .centre         (frame.centre),
        .surround_left  (frame.surround_left),
        .surround_right (frame.surround_right),
        .left_out       (stereo.left_out),
        .right_out      (stereo.right_out)
    );

    assign frame.ready  = rdy1;
    assign stereo.valid = v4_reg;

`ifndef SYNTHESIS
    // The input may only be held off once every stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v2_reg && v3_reg && v4_reg) |-> frame.ready)
        else $error("frame channel stalled with room in the pipeline");

    // With the receiver ready throughout, an accepted word passes through every stage to the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 4) && $past(frame.valid && frame.ready, 4)
            && $past(stereo.ready, 1) && $past(stereo.ready, 2)
            && $past(stereo.ready, 3))
        |-> stereo.valid)
        else $error("accepted word did not reach the output in four cycles");

    // A stage never loads without a valid word in front of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.load2 || v1_reg) && (!ctrl.load3 || v2_reg) && (!ctrl.load4 || v3_reg))
        else $error("pipeline stage loaded from an empty stage");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for surround_downmix_to_stereo_top: frame words with
// random handshake gaps, checked against an in-bench downmix predictor.
// Depends on sdm_pkg, sdm_frame_if, sdm_stereo_if and the top-level RTL.
`timescale 1ns / 100ps

module tb;
    import sdm_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 11;
    localparam int PIPE_LATENCY      = 4;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int IDLE_PERCENT      = 16;
    localparam int LONG_STALL_CYCLES = 60;
    localparam int REPORT_LIMIT      = 10;

    localparam longint SIDE_GAIN_NUM = 5818;
    localparam longint SIDE_GAIN_DEN = 8192;
    localparam longint MIX_GAIN_NUM  = 5248;
    localparam longint MIX_GAIN_DEN  = 16384;
    localparam longint PCM_MAX       = 32767;
    localparam longint PCM_MIN       = -32768;

    typedef struct packed {
        sample_t front_left;
        sample_t front_right;
        sample_t centre;
        sample_t bass_channel;
        sample_t surround_left;
        sample_t surround_right;
    } frame_word_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
    } stereo_word_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    chan_count_t wr_data;

    sdm_frame_if  frame_ch();
    sdm_stereo_if stereo_ch();

    surround_downmix_to_stereo_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .frame   (frame_ch),
        .stereo  (stereo_ch)
    );

    chan_count_t  active_count;
    stereo_word_t expected_pairs[$];
    bit           steady;
    bit           stall_pending;
    int           stalls_done;
    int           mismatches;
    int           words_checked;
    int           counts_seen;
    int           cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, expected_pairs.size());
            $display("tb failed");
            $finish;
        end
    end

    function automatic sample_t clip_sample(longint x);
        longint y;
        y = x;
        if (y > PCM_MAX)
        begin
            y = PCM_MAX;
        end
        else if (y < PCM_MIN)
        begin
            y = PCM_MIN;
        end
        return sample_t'(y);
    endfunction

    function automatic stereo_word_t downmix(frame_word_t f, chan_count_t count);
        stereo_word_t s;
        longint c;
        longint sl;
        longint sr;
        if (count == MIX_COUNT)
        begin
            c  = longint'(f.centre) * SIDE_GAIN_NUM / SIDE_GAIN_DEN;
            sl = longint'(f.surround_left) * SIDE_GAIN_NUM / SIDE_GAIN_DEN;
            sr = longint'(f.surround_right) * SIDE_GAIN_NUM / SIDE_GAIN_DEN;
            s.left_out  = clip_sample((longint'(f.front_left) + c + sl)
                                      * MIX_GAIN_NUM / MIX_GAIN_DEN);
            s.right_out = clip_sample((longint'(f.front_right) + c + sr)
                                      * MIX_GAIN_NUM / MIX_GAIN_DEN);
        end
        else
        begin
            s.left_out  = f.front_left;
            s.right_out = f.front_right;
        end
        return s;
    endfunction

    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(7))
            0: v = 16'sh7fff;
            1: v = -16'sh8000;
            2: v = 16'sh0000;
            3: v = sample_t'($urandom_range(8)) - 16'sd4;
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic frame_word_t random_frame();
        frame_word_t f;
        f.front_left     = pick_sample();
        f.front_right    = pick_sample();
        f.centre         = pick_sample();
        f.bass_channel   = pick_sample();
        f.surround_left  = pick_sample();
        f.surround_right = pick_sample();
        return f;
    endfunction

    function automatic frame_word_t make_frame(int fl, int fr, int c, int lfe,
                                               int sl, int sr);
        frame_word_t f;
        f.front_left     = sample_t'(fl);
        f.front_right    = sample_t'(fr);
        f.centre         = sample_t'(c);
        f.bass_channel   = sample_t'(lfe);
        f.surround_left  = sample_t'(sl);
        f.surround_right = sample_t'(sr);
        return f;
    endfunction

    task automatic send_frame(input frame_word_t f);
        while (!steady && ($urandom_range(99) < IDLE_PERCENT))
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.front_left     <= f.front_left;
        frame_ch.front_right    <= f.front_right;
        frame_ch.centre         <= f.centre;
        frame_ch.bass_channel   <= f.bass_channel;
        frame_ch.surround_left  <= f.surround_left;
        frame_ch.surround_right <= f.surround_right;
        do
        begin
            @(posedge clk);
        end
        while (!frame_ch.ready);
        expected_pairs.push_back(downmix(f, active_count));
    endtask

    task automatic drain();
        frame_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_pairs.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_count(input chan_count_t count);
        wr_en   <= 1'b1;
        wr_data <= count;
        @(posedge clk);
        wr_en   <= 1'b0;
        active_count = count;
        counts_seen++;
        @(posedge clk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_frame(random_frame());
    endtask

    always @(posedge clk)
    begin
        stereo_word_t want;
        if (rst_n && stereo_ch.valid && stereo_ch.ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Unexpected stereo word L=%0d R=%0d at cycle %0d.",
                             stereo_ch.left_out, stereo_ch.right_out, cycle_count);
                end
            end
            else
            begin
                want = expected_pairs.pop_front();
                words_checked++;
                if (stereo_ch.left_out !== want.left_out ||
                    stereo_ch.right_out !== want.right_out)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("Word %0d: expected L=%0d R=%0d, got L=%0d R=%0d.",
                                 words_checked, want.left_out, want.right_out,
                                 stereo_ch.left_out, stereo_ch.right_out);
                    end
                end
            end
        end
    end

    initial
    begin
        stereo_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pending)
            begin
                stall_pending = 1'b0;
                stereo_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                stalls_done++;
            end
            stereo_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic test_reset_downmix();
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(32767, 32767, 32767, 32767, 32767, 32767));
        send_frame(make_frame(-32768, -32768, -32768, -32768, -32768, -32768));
        send_frame(make_frame(32767, -32768, 0, 0, 32767, -32768));
        send_frame(make_frame(0, 0, -1, 0, 0, 0));
        send_frame(make_frame(0, 0, 1, 0, 0, 0));
        send_frame(make_frame(-1, -4, 0, 0, 0, 0));
        send_frame(make_frame(0, 0, 0, 0, -2, 3));
        send_frame(make_frame(0, 0, 0, 32767, 0, 0));
        send_frame(make_frame(0, 0, 0, -32768, 0, 0));
        send_frame(make_frame(12345, -23456, -1000, 555, -2, 3));
        drain();
    endtask

    task automatic test_pass_through();
        write_count(4'd0);
        send_frame(make_frame(32767, -32768, 1234, -5, 32767, -32768));
        drain();
        write_count(4'd15);
        send_frame(make_frame(-1, 0, -32768, 32767, -32768, 32767));
        drain();
        write_count(4'd3);
        send_frame(make_frame(-32768, 32767, 32767, 0, 32767, 32767));
        drain();
        write_count(4'd8);
        send_frame(make_frame(1, -1, -1, -1, -1, -1));
        drain();
        write_count(4'd5);
        send_frame(make_frame(100, -200, 300, -400, 500, -600));
        drain();
        write_count(4'd7);
        send_frame(make_frame(-7, 7, 32767, 32767, -32768, -32768));
        drain();
    endtask

    task automatic test_random_downmix();
        write_count(MIX_COUNT);
        send_random(100);
        steady = 1'b1;
        send_random(120);
        steady = 1'b0;
        send_random(80);
        drain();
    endtask

    task automatic test_backpressure();
        stall_pending = 1'b1;
        send_random(40);
        drain();
    endtask

    task automatic test_random_counts();
        chan_count_t sweep[8];
        sweep[0] = 4'd15;
        sweep[1] = 4'd0;
        sweep[2] = 4'd6;
        sweep[3] = 4'd8;
        sweep[4] = 4'd3;
        sweep[5] = chan_count_t'($urandom_range(15));
        sweep[6] = chan_count_t'($urandom_range(15));
        sweep[7] = 4'd6;
        foreach (sweep[i])
        begin
            write_count(sweep[i]);
            send_random(40);
            drain();
        end
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        wr_en                   <= 1'b0;
        wr_data                 <= '0;
        frame_ch.valid          <= 1'b0;
        frame_ch.front_left     <= '0;
        frame_ch.front_right    <= '0;
        frame_ch.centre         <= '0;
        frame_ch.bass_channel   <= '0;
        frame_ch.surround_left  <= '0;
        frame_ch.surround_right <= '0;
        active_count  = CH_COUNT_RESET;
        steady        = 1'b0;
        stall_pending = 1'b0;
        stalls_done   = 0;
        mismatches    = 0;
        words_checked = 0;
        counts_seen   = 1;
        cycle_count   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_downmix();
        test_pass_through();
        test_random_downmix();
        test_backpressure();
        test_random_counts();

        $display("Checked %0d stereo words across %0d channel-count settings,",
                 words_checked, counts_seen);
        $display("with random handshake gaps and %0d long receiver stall(s).",
                 stalls_done);
        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("%0d mismatches in total.", mismatches);
            $display("tb failed");
        end
        $finish;
    end

endmodule
